/* design/jul_pkg.sv */
package jul_pkg;

  // defaults for the top level parameters
  localparam int DEF_IMG_WIDTH  = 1024;
  localparam int DEF_IMG_HEIGHT = 1024;
  localparam int DEF_ITER_BITS  = 16;

  // configuration register indexes
  localparam logic [2:0] REG_C_RE     = 3'd0;
  localparam logic [2:0] REG_C_IM     = 3'd1;
  localparam logic [2:0] REG_MAX_ITER = 3'd2;
  localparam logic [2:0] REG_STEP_X   = 3'd3;
  localparam logic [2:0] REG_STEP_Y   = 3'd4;
  localparam logic [2:0] REG_ORIGIN   = 3'd5;

  // register reset values
  localparam logic signed [31:0] RST_C_RE     = 32'sd0;
  localparam logic signed [31:0] RST_C_IM     = 32'sd0;
  localparam logic [15:0]        RST_MAX_ITER = 16'd256;
  localparam logic signed [31:0] RST_STEP_X   = 32'sd49152;
  localparam logic signed [31:0] RST_STEP_Y   = 32'sd49152;
  localparam logic signed [31:0] RST_ORIGIN   = -32'sd25165824;

  // escape when |z|^2 >= 16, in Q16.48
  localparam logic [63:0] ESC_BOUND = 64'd16 << 48;

  // gradient constants
  localparam int         QUOT_W     = 8;
  localparam logic [7:0] GRAD_K1    = 8'd180;
  localparam logic [7:0] GRAD_K2    = 8'd165;
  localparam logic [7:0] GRAD_BASE1 = 8'd255;
  localparam logic [7:0] GRAD_BASE2 = 8'd165;
  localparam logic [7:0] RED_LEVEL  = 8'd255;
  localparam logic [7:0] BLUE_LEVEL = 8'd0;

  typedef struct packed {
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
  } in_word_t;

  typedef struct packed {
    logic [15:0] iterations;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  blue;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] c_re;
    logic signed [31:0] c_im;
    logic [15:0]        max_iter;
    logic signed [31:0] step_x;
    logic signed [31:0] step_y;
    logic signed [31:0] origin;
  } cfg_regs_t;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MAP_MUL,
    OP_MAP_ADD,
    OP_SQ_MUL,
    OP_UPDATE,
    OP_DIV_LOAD,
    OP_EMIT
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_IN,
    C_DONE,
    C_NOT_ESC,
    C_DIV_BUSY,
    C_OUT_BUSY
  } cond_t;

  typedef logic [2:0] upc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  jmp;
  } ctrl_t;

  // status seen by the sequencer
  typedef struct packed {
    logic no_in;
    logic done;
    logic esc;
    logic div_busy;
    logic out_busy;
  } seq_stat_t;

  // status from the datapath
  typedef struct packed {
    logic done;
    logic esc;
  } dp_stat_t;

  // program step addresses
  localparam upc_t STEP_WAIT  = 3'd0;
  localparam upc_t STEP_MAPM  = 3'd1;
  localparam upc_t STEP_MAPA  = 3'd2;
  localparam upc_t STEP_SQM   = 3'd3;
  localparam upc_t STEP_UPD   = 3'd4;
  localparam upc_t STEP_COLOR = 3'd5;
  localparam upc_t STEP_DIVW  = 3'd6;
  localparam upc_t STEP_EMIT  = 3'd7;

  localparam int UCODE_DEPTH = 8;

  // control store: a taken condition jumps, otherwise the step counter
  // advances; the last step wraps back to the wait step
  localparam ctrl_t UCODE [UCODE_DEPTH] = '{
    '{op: OP_LOAD,     cond: C_NO_IN,    jmp: STEP_WAIT},
    '{op: OP_MAP_MUL,  cond: C_NEVER,    jmp: STEP_WAIT},
    '{op: OP_MAP_ADD,  cond: C_NEVER,    jmp: STEP_WAIT},
    '{op: OP_SQ_MUL,   cond: C_DONE,     jmp: STEP_COLOR},
    '{op: OP_UPDATE,   cond: C_NOT_ESC,  jmp: STEP_SQM},
    '{op: OP_DIV_LOAD, cond: C_NEVER,    jmp: STEP_WAIT},
    '{op: OP_NONE,     cond: C_DIV_BUSY, jmp: STEP_DIVW},
    '{op: OP_EMIT,     cond: C_OUT_BUSY, jmp: STEP_EMIT}
  };

endpackage

/* design/jul_seq.sv */
module jul_seq
  import jul_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  seq_stat_t stat,
  output ctrl_t     ctrl
);

  upc_t pc_r, pc_nxt;
  logic taken;

  // fetch the current control word
  assign ctrl = UCODE[pc_r];

  // jump condition decode
  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:    taken = 1'b0;
      C_NO_IN:    taken = stat.no_in;
      C_DONE:     taken = stat.done;
      C_NOT_ESC:  taken = !stat.esc;
      C_DIV_BUSY: taken = stat.div_busy;
      C_OUT_BUSY: taken = stat.out_busy;
      default:    taken = 1'b0;
    endcase
  end

  // step counter, wraps at the end of the program
  assign pc_nxt = taken ? ctrl.jmp : upc_t'(pc_r + 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* design/jul_div.sv */
module jul_div
  import jul_pkg::*;
#(
  parameter int NUM_W = DEF_ITER_BITS + 8,
  parameter int DEN_W = DEF_ITER_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic              busy,
  output logic [QUOT_W-1:0] quot
);

  localparam int K_W = $clog2(QUOT_W);

  logic [NUM_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [QUOT_W-1:0] q_r, q_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic              busy_r, busy_nxt;
  logic [NUM_W-1:0]  dshift;
  logic [NUM_W:0]    trial;

  // restoring division, one quotient bit per cycle from the top;
  // the quotient is known to fit in QUOT_W bits
  assign dshift = NUM_W'(den_r) << k_r;
  assign trial  = {1'b0, rem_r} - {1'b0, dshift};

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = num;
      den_nxt  = den;
      q_nxt    = '0;
      k_nxt    = K_W'(QUOT_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[NUM_W]) begin
        rem_nxt   = trial[NUM_W-1:0];
        q_nxt[k_r] = 1'b1;
      end
      if (k_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        k_nxt = k_r - K_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
    k_r   <= k_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;

  // no restart while a division runs
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  // the last quotient bit ends the division
  a_last_bit: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start && (k_r == '0) |=> !busy_r)
    else $error("divider did not finish after last bit");

endmodule

/* design/jul_dp.sv */
module jul_dp
  import jul_pkg::*;
#(
  parameter int IMG_WIDTH  = DEF_IMG_WIDTH,
  parameter int IMG_HEIGHT = DEF_IMG_HEIGHT,
  parameter int ITER_BITS  = DEF_ITER_BITS,
  parameter int NUM_W      = DEF_ITER_BITS + 8
) (
  input  logic                 clk,
  input  ctrl_t                ctrl,
  input  logic                 load_fire,
  input  in_word_t             in_word,
  input  cfg_regs_t            cfg,
  output dp_stat_t             stat,
  output logic [ITER_BITS-1:0] iter,
  output logic [NUM_W-1:0]     div_num,
  output logic [ITER_BITS-1:0] div_den,
  output logic [7:0]           base
);

  localparam logic [31:0] ITER_CAP = 32'((64'd1 << ITER_BITS) - 64'd1);

  logic [9:0]                px_r, px_nxt, py_r, py_nxt;
  logic [ITER_BITS-1:0]      lim_r, lim_nxt, it_r, it_nxt;
  logic signed [31:0]        zr_r, zr_nxt, zi_r, zi_nxt;
  logic signed [63:0]        p0_r, p0_nxt, p1_r, p1_nxt, p2_r, p2_nxt;
  logic [7:0]                base_r, base_nxt;
  logic signed [31:0]        ma0, mb0, ma1, mb1;
  logic signed [63:0]        prod0, prod1, prod2;
  logic [63:0]               mag;
  logic [63:0]               diff;
  logic [ITER_BITS:0]        twice;
  logic [ITER_BITS:0]        excess;
  logic                      map_sel;

  // multiplier operands: pixel times step while mapping, z terms otherwise
  assign map_sel = (ctrl.op == OP_MAP_MUL);
  assign ma0 = map_sel ? $signed(32'(px_r)) : zr_r;
  assign mb0 = map_sel ? cfg.step_x : zr_r;
  assign ma1 = map_sel ? $signed(32'(py_r)) : zi_r;
  assign mb1 = map_sel ? cfg.step_y : zi_r;
  assign prod0 = ma0 * mb0;
  assign prod1 = ma1 * mb1;
  assign prod2 = zr_r * zi_r;

  // escape test on the exact squared magnitude
  assign mag  = $unsigned(p0_r) + $unsigned(p1_r);
  assign diff = $unsigned(p0_r) - $unsigned(p1_r);
  assign stat.esc  = (mag >= ESC_BOUND);
  assign stat.done = (it_r >= lim_r);

  // gradient segment selection
  assign twice  = {it_r, 1'b0};
  assign excess = twice - {1'b0, lim_r};

  always_comb begin
    px_nxt   = px_r;
    py_nxt   = py_r;
    lim_nxt  = lim_r;
    it_nxt   = it_r;
    zr_nxt   = zr_r;
    zi_nxt   = zi_r;
    p0_nxt   = p0_r;
    p1_nxt   = p1_r;
    p2_nxt   = p2_r;
    base_nxt = base_r;
    div_num  = '0;
    div_den  = ITER_BITS'(1);
    unique case (ctrl.op) inside
      OP_LOAD: begin
        if (load_fire) begin
          px_nxt = (32'(in_word.pixel_x) > 32'(IMG_WIDTH - 1)) ?
                   10'(IMG_WIDTH - 1) : in_word.pixel_x;
          py_nxt = (32'(in_word.pixel_y) > 32'(IMG_HEIGHT - 1)) ?
                   10'(IMG_HEIGHT - 1) : in_word.pixel_y;
          lim_nxt = (32'(cfg.max_iter) > ITER_CAP) ?
                    ITER_BITS'(ITER_CAP) : ITER_BITS'(cfg.max_iter);
          it_nxt  = '0;
        end
      end
      OP_MAP_MUL, OP_SQ_MUL: begin
        p0_nxt = prod0;
        p1_nxt = prod1;
        p2_nxt = prod2;
      end
      OP_MAP_ADD: begin
        zr_nxt = cfg.origin + $signed(p0_r[31:0]);
        zi_nxt = cfg.origin + $signed(p1_r[31:0]);
      end
      OP_UPDATE: begin
        // z = z*z + c, kept only when the point has not escaped
        if (!stat.esc) begin
          zr_nxt = $signed(diff[55:24]) + cfg.c_re;
          zi_nxt = $signed(p2_r[54:23]) + cfg.c_im;
          it_nxt = it_r + ITER_BITS'(1);
        end
      end
      OP_DIV_LOAD: begin
        if (lim_r == '0) begin
          div_num  = '0;
          div_den  = ITER_BITS'(1);
          base_nxt = GRAD_BASE1;
        end else if (twice < {1'b0, lim_r}) begin
          div_num  = NUM_W'(NUM_W'(it_r) * NUM_W'(GRAD_K1));
          div_den  = lim_r;
          base_nxt = GRAD_BASE1;
        end else begin
          div_num  = NUM_W'(NUM_W'(excess) * NUM_W'(GRAD_K2));
          div_den  = lim_r;
          base_nxt = GRAD_BASE2;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    lim_r  <= lim_nxt;
    it_r   <= it_nxt;
    zr_r   <= zr_nxt;
    zi_r   <= zi_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    base_r <= base_nxt;
  end

  assign iter = it_r;
  assign base = base_r;

endmodule

/* design/julia_escape_time_pixel.sv */
// Julia set escape-time pixel unit. Each input word carries a pixel
// column and row; the unit maps it to z0 = origin + pixel*step in Q8.24,
// iterates z = z*z + c until |z|^2 reaches 16 or the count reaches
// max_iter, and returns the count with a yellow-orange-red color (red 255,
// blue 0, green from an exact integer gradient). One pixel is in flight at
// a time. A small control program steps a datapath with three 32x32
// multipliers, spending one step on the products and one on the escape
// test and update for each iteration, then runs a bit-serial divider for
// the color. The result sits in an output register, so the next pixel is
// taken while it waits. Configuration is written through cfg_we, cfg_index
// and cfg_data; the user must write it only while the unit is idle, which
// the unit itself does not enforce.
module julia_escape_time_pixel
  import jul_pkg::*;
#(
  parameter int IMG_WIDTH  = DEF_IMG_WIDTH,
  parameter int IMG_HEIGHT = DEF_IMG_HEIGHT,
  parameter int ITER_BITS  = DEF_ITER_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NUM_W = ITER_BITS + 8;

  cfg_regs_t            cfg_r, cfg_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_word_r, out_word_nxt;
  ctrl_t                ctrl;
  seq_stat_t            sstat;
  dp_stat_t             dstat;
  logic                 in_fire;
  logic                 out_busy;
  logic                 emit;
  logic                 div_busy;
  logic [QUOT_W-1:0]    quot;
  logic [ITER_BITS-1:0] iter;
  logic [NUM_W-1:0]     div_num;
  logic [ITER_BITS-1:0] div_den;
  logic [7:0]           base;

  // input word taken only in the wait step
  assign in_stall = (ctrl.op != OP_LOAD);
  assign in_fire  = in_valid && !in_stall;

  // output slot is busy while a word waits and is not taken
  assign out_busy = out_valid_r && out_stall;
  assign emit     = (ctrl.op == OP_EMIT) && !out_busy;

  assign sstat.no_in    = !in_fire;
  assign sstat.done     = dstat.done;
  assign sstat.esc      = dstat.esc;
  assign sstat.div_busy = div_busy;
  assign sstat.out_busy = out_busy;

  jul_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (sstat),
    .ctrl  (ctrl)
  );

  jul_dp #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT),
    .ITER_BITS  (ITER_BITS),
    .NUM_W      (NUM_W)
  ) u_dp (
    .clk       (clk),
    .ctrl      (ctrl),
    .load_fire (in_fire),
    .in_word   (in_word),
    .cfg       (cfg_r),
    .stat      (dstat),
    .iter      (iter),
    .div_num   (div_num),
    .div_den   (div_den),
    .base      (base)
  );

  jul_div #(
    .NUM_W (NUM_W),
    .DEN_W (ITER_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctrl.op == OP_DIV_LOAD),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (quot)
  );

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_C_RE:     cfg_nxt.c_re     = $signed(cfg_data);
        REG_C_IM:     cfg_nxt.c_im     = $signed(cfg_data);
        REG_MAX_ITER: cfg_nxt.max_iter = cfg_data[15:0];
        REG_STEP_X:   cfg_nxt.step_x   = $signed(cfg_data);
        REG_STEP_Y:   cfg_nxt.step_y   = $signed(cfg_data);
        REG_ORIGIN:   cfg_nxt.origin   = $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c_re     <= RST_C_RE;
      cfg_r.c_im     <= RST_C_IM;
      cfg_r.max_iter <= RST_MAX_ITER;
      cfg_r.step_x   <= RST_STEP_X;
      cfg_r.step_y   <= RST_STEP_Y;
      cfg_r.origin   <= RST_ORIGIN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (emit) begin
      out_valid_nxt           = 1'b1;
      out_word_nxt.iterations = 16'(iter);
      out_word_nxt.green      = base - quot;
      out_word_nxt.red        = RED_LEVEL;
      out_word_nxt.blue       = BLUE_LEVEL;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // one pixel at a time: an accepted word closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after accept");

  // color is read only after the division has finished
  a_emit_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_EMIT) |-> !div_busy)
    else $error("result emitted while divider busy");

  // a new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !emit)
    else $error("output word overwritten");

endmodule

/* tb/julia_escape_time_pixel_test.sv */
`timescale 1ns / 100ps

module julia_escape_time_pixel_test;
  import jul_pkg::*;

  localparam int LIMIT_CYCLES  = 4_000_000;
  localparam int HOLD_CYCLES   = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam int Q_ONE = 1 << 24;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY} stall_mode_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_word_t    in_word   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = REG_C_RE;
  logic [31:0] cfg_data  = '0;

  julia_escape_time_pixel dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow copy of the configuration registers
  logic [31:0] sh_c_re     = RST_C_RE;
  logic [31:0] sh_c_im     = RST_C_IM;
  logic [15:0] sh_max_iter = RST_MAX_ITER;
  logic [31:0] sh_step_x   = RST_STEP_X;
  logic [31:0] sh_step_y   = RST_STEP_Y;
  logic [31:0] sh_origin   = RST_ORIGIN;

  out_word_t pixel_q [$];
  out_word_t want_word;
  int        err_count   = 0;
  int        cycle_count = 0;

  // sender burst state
  bit offering   = 1'b0;
  int burst_left = 0;
  int gap_next   = 1;

  // receiver stall state
  stall_mode_t stall_mode  = STALL_NONE;
  int          seg_left    = 0;
  int          hold_left   = 0;
  int          hold_ticket = 0;
  int          hold_served = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // escape-time count and gradient color of one pixel
  function automatic out_word_t julia_pixel(input in_word_t w);
    logic [31:0]        px, py, zr, zi, lim, cap, it, g;
    logic signed [63:0] x, y;
    logic [63:0]        xx, yy, xy, diff;
    logic               escaped;
    out_word_t          r;
    px = 32'(w.pixel_x);
    py = 32'(w.pixel_y);
    if (px > DEF_IMG_WIDTH - 1) px = DEF_IMG_WIDTH - 1;
    if (py > DEF_IMG_HEIGHT - 1) py = DEF_IMG_HEIGHT - 1;
    zr = sh_origin + px * sh_step_x;
    zi = sh_origin + py * sh_step_y;
    cap = (32'd1 << DEF_ITER_BITS) - 32'd1;
    lim = 32'(sh_max_iter);
    if (lim > cap) lim = cap;
    it = 0;
    escaped = 1'b0;
    // z = z*z + c with exact products, wrapping 32-bit parts
    while (!escaped && it < lim) begin
      x = 64'($signed(zr));
      y = 64'($signed(zi));
      xx = x * x;
      yy = y * y;
      xy = x * y;
      if (xx + yy >= ESC_BOUND) begin
        escaped = 1'b1;
      end else begin
        diff = xx - yy;
        zr = diff[55:24] + sh_c_re;
        zi = xy[54:23] + sh_c_im;
        it++;
      end
    end
    // two-segment gradient
    if (lim == 0) g = 255;
    else if (2 * it < lim) g = 255 - (180 * it) / lim;
    else g = 165 - (165 * (2 * it - lim)) / lim;
    r.iterations = it[15:0];
    r.green      = g[7:0];
    r.red        = 8'd255;
    r.blue       = 8'd0;
    return r;
  endfunction

  function automatic in_word_t pix(input int x, input int y);
    in_word_t w;
    w.pixel_x = x[9:0];
    w.pixel_y = y[9:0];
    return w;
  endfunction

  function automatic int rand_span(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want_word = pixel_q.pop_front();
        check_field("iterations", out_word.iterations, want_word.iterations);
        check_field("green", {8'd0, out_word.green}, {8'd0, want_word.green});
        check_field("red", {8'd0, out_word.red}, {8'd0, want_word.red});
        check_field("blue", {8'd0, out_word.blue}, {8'd0, want_word.blue});
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_ticket != hold_served) begin
      hold_served <= hold_ticket;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        seg_left   <= $urandom_range(10, 150);
      end else begin
        seg_left <= seg_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 1);
        default:     out_stall <= ((seg_left % 5) < 2);
      endcase
    end
  end

  // send one pixel word, in bursts with gaps between them
  task automatic send_pixel(input in_word_t w);
    if (!offering) begin
      repeat (gap_next) @(posedge clk);
      in_valid  <= 1'b1;
      offering   = 1'b1;
      burst_left = $urandom_range(1, 24);
    end
    in_word <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    pixel_q.push_back(julia_pixel(w));
    burst_left--;
    if (burst_left == 0) begin
      gap_next = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      offering  = 1'b0;
    end
  endtask

  task automatic drop_input();
    if (offering) begin
      in_valid <= 1'b0;
      offering  = 1'b0;
    end
  endtask

  task automatic drain_results();
    drop_input();
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_C_RE:     sh_c_re     = val;
      REG_C_IM:     sh_c_im     = val;
      REG_MAX_ITER: sh_max_iter = val[15:0];
      REG_STEP_X:   sh_step_x   = val;
      REG_STEP_Y:   sh_step_y   = val;
      REG_ORIGIN:   sh_origin   = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_view(input logic [31:0] c_re, input logic [31:0] c_im,
                          input logic [31:0] lim, input logic [31:0] sx,
                          input logic [31:0] sy, input logic [31:0] org);
    wait_idle();
    write_reg(REG_C_RE, c_re);
    write_reg(REG_C_IM, c_im);
    write_reg(REG_MAX_ITER, lim);
    write_reg(REG_STEP_X, sx);
    write_reg(REG_STEP_Y, sy);
    write_reg(REG_ORIGIN, org);
  endtask

  // default view straight out of reset, center point never escapes
  task automatic test_reset_values();
    send_pixel(pix(0, 0));
    send_pixel(pix(1023, 1023));
    send_pixel(pix(512, 512));
    send_pixel(pix(1023, 0));
    send_pixel(pix(0, 512));
  endtask

  // limit of zero: no iteration, brightest green
  task automatic test_zero_limit();
    wait_idle();
    write_reg(REG_MAX_ITER, 32'hA5C3_0000);
    send_pixel(pix(512, 512));
    send_pixel(pix(0, 1023));
  endtask

  // extreme registers: wrap in the mapping and in the update
  task automatic test_wrap_extremes();
    set_view(Q_MAX, Q_MIN, 32'd4, Q_MAX, Q_MIN, Q_MIN);
    send_pixel(pix(0, 0));
    send_pixel(pix(1023, 1023));
    send_pixel(pix(1, 1023));
    send_pixel(pix(1023, 1));
    set_view(Q_MAX, Q_MAX, 32'h5A5A_0007, 32'd1, 32'hFFFF_FFFF, 32'd0);
    send_pixel(pix(0, 0));
    send_pixel(pix(1023, 1023));
    set_view(Q_MIN, Q_MIN, 32'd9, 32'd49152, 32'd49152, -32'sd65011712);
    send_pixel(pix(1023, 1023));
  endtask

  // widest limit: one point that never escapes, one that escapes at once
  task automatic test_long_limit();
    set_view(32'd0, 32'd0, 32'h0000_FFFF, 32'd0, 32'd0, 32'd0);
    send_pixel(pix(1023, 1023));
    wait_idle();
    write_reg(REG_ORIGIN, 32'h0400_0000);
    send_pixel(pix(0, 0));
  endtask

  // a classic constant, c = -0.8 + 0.156i, over the default frame
  task automatic test_known_constant();
    set_view(-32'sd13421773, 32'sd2617245, 32'd64, RST_STEP_X, RST_STEP_Y, RST_ORIGIN);
    send_pixel(pix(0, 0));
    send_pixel(pix(512, 512));
    send_pixel(pix(300, 700));
    send_pixel(pix(1023, 0));
    send_pixel(pix(640, 384));
  endtask

  // random views over the plane, random pixels within each
  task automatic test_random_views(input int phases, input int per_phase,
                                   input int lim_lo, input int lim_hi);
    int          p, i;
    logic [31:0] lim_word, sx, sy;
    for (p = 0; p < phases; p++) begin
      lim_word = $urandom;
      lim_word[15:0] = 16'($urandom_range(lim_lo, lim_hi));
      if ($urandom_range(0, 7) == 0) begin
        set_view($urandom, $urandom, lim_word, $urandom, $urandom, $urandom);
      end else begin
        sx = $urandom_range(4000, 200000);
        sy = $urandom_range(4000, 200000);
        if ($urandom_range(0, 3) == 0) sx = -sx;
        if ($urandom_range(0, 3) == 0) sy = -sy;
        set_view(rand_span(-20132659, 20132659), rand_span(-20132659, 20132659),
                 lim_word, sx, sy, rand_span(-2 * Q_ONE, Q_ONE / 2));
      end
      for (i = 0; i < per_phase; i++) begin
        if (i == per_phase / 2 && $urandom_range(0, 2) == 0) drain_results();
        send_pixel(pix($urandom_range(0, 1023), $urandom_range(0, 1023)));
      end
    end
  endtask

  // receiver holds off long enough that the unit stalls its input
  task automatic test_output_hold();
    int i;
    set_view(-32'sd13421773, 32'sd2617245, 32'd6, RST_STEP_X, RST_STEP_Y, RST_ORIGIN);
    hold_ticket <= hold_ticket + 1;
    for (i = 0; i < 16; i++)
      send_pixel(pix($urandom_range(0, 1023), $urandom_range(0, 1023)));
  endtask

  // timeout
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // main sequence
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);
    test_reset_values();
    test_zero_limit();
    test_wrap_extremes();
    test_long_limit();
    test_known_constant();
    test_random_views(8, 100, 1, 40);
    test_output_hold();
    test_random_views(1, 60, 100, 256);
    test_random_views(3, 60, 1, 12);
    wait_idle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
design/jul_pkg.sv
design/jul_seq.sv
design/jul_div.sv
design/jul_dp.sv
design/julia_escape_time_pixel.sv
tb/julia_escape_time_pixel_test.sv
